FILE: hdl/conjugate_gradient_solver_core_assert.svh
// assertion macros for the conjugate gradient solver core
`ifndef CONJUGATE_GRADIENT_SOLVER_CORE_ASSERT_SVH
`define CONJUGATE_GRADIENT_SOLVER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CGS_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CGS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/cgs_pkg.sv
// shared types, constants and arithmetic helpers of the solver core
`default_nettype none
package cgs_pkg;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int IDX_W     = 4;
  localparam int ITER_W    = 7;
  localparam int SIZE_W    = 5;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_SOLVE  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE = 1'd0,
    CFG_TOL  = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quo;
  } div_rsp_t;

  localparam logic signed [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] S32_MAX_X = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN_X = -64'sd2147483648;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

  function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? S64_MIN : S64_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > S32_MAX_X) begin
      return S32_MAX;
    end
    if (v < S32_MIN_X) begin
      return S32_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/cgs_in_if.sv
// input item channel of the solver core
`default_nettype none
interface cgs_in_if;
  import cgs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         column;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output row, output column, output value,
                  input ready);
  modport sink (input valid, input action, input row, input column, input value,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/cgs_out_if.sv
// result item channel of the solver core
`default_nettype none
interface cgs_out_if;
  import cgs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] solution;
  logic                     last;
  logic                     converged;
  logic [ITER_W-1:0]        iterations;

  modport source (output valid, output index, output solution, output last,
                  output converged, output iterations, input ready);
  modport sink (input valid, input index, input solution, input last,
                input converged, input iterations, output ready);
endinterface
`default_nettype wire

FILE: hdl/cgs_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module cgs_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/cgs_div.sv
// iterative signed divider for (num * 2^16) / den, one quotient bit a cycle
`default_nettype none
module cgs_div import cgs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  localparam int QW = DIV_STEPS;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]        dvd_r, dvd_nxt;
  logic [DATA_W-1:0]    den_r, den_nxt;
  logic                 neg_r, neg_nxt;

  logic [DATA_W:0] num_x, den_x, num_mag, den_mag, rem_sh;
  logic            ge;

  always_comb begin
    num_x   = {req.num[DATA_W-1], req.num};
    den_x   = {req.den[DATA_W-1], req.den};
    num_mag = num_x[DATA_W] ? (DATA_W+1)'(-num_x) : num_x;
    den_mag = den_x[DATA_W] ? (DATA_W+1)'(-den_x) : den_x;
    rem_sh  = {rem_r, dvd_r[QW-1]};
    ge      = rem_sh >= {1'b0, den_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(QW - 1);
      rem_nxt  = '0;
      dvd_nxt  = {num_mag[DATA_W-1:0], 16'h0000};
      den_nxt  = den_mag[DATA_W-1:0];
      neg_nxt  = req.num[DATA_W-1] ^ req.den[DATA_W-1];
    end else if (busy_r) begin
      rem_nxt = ge ? DATA_W'(rem_sh - {1'b0, den_r}) : rem_sh[DATA_W-1:0];
      dvd_nxt = {dvd_r[QW-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    rsp.done = done_r;
    if (!neg_r) begin
      rsp.quo = (dvd_r > QW'(32'h7FFFFFFF)) ? S32_MAX : dvd_r[DATA_W-1:0];
    end else begin
      rsp.quo = (dvd_r > QW'(32'h80000000)) ? S32_MIN : DATA_W'(-dvd_r[DATA_W-1:0]);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/conjugate_gradient_solver_core.sv
// top level of the conjugate gradient solver core
//
//  port        dir  handshake     carries
//  in_if       in   valid/ready   action, row, column, value
//  out_if      out  valid/ready   index, solution, last, converged, iterations
//  cfg_*       in   write enable  size_in_use, tolerance_squared
//
//  load items are taken only while idle; a solve holds in_if.ready low until its last result is taken
//  a full iteration is the matrix-vector pass, five vector passes and two divides; each
//  result passes through the states S_ORD, S_OLD and S_OWAIT, the last waiting out any
//  output stall
//  synchronous active-low reset clears control state only; no clearing pass is needed
`default_nettype none
module conjugate_gradient_solver_core import cgs_pkg::*; #(
  parameter int N        = 16,
  parameter int MAX_ITER = 64
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  cgs_in_if.sink                   in_if,
  cgs_out_if.source                out_if,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_idx,
  input wire logic [DATA_W-1:0]    cfg_wdata
);
  localparam int NW  = $clog2(N);
  localparam int MAW = $clog2(N * N);
  localparam int LIM = (N < 16) ? N : 16;
  localparam int IW  = $clog2(MAX_ITER + 1);
  localparam int EW  = (IW > ITER_W) ? IW : ITER_W;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_INIT  = 13'b0000000000010,
    S_RR    = 13'b0000000000100,
    S_AP    = 13'b0000000001000,
    S_PAP   = 13'b0000000010000,
    S_DIVA  = 13'b0000000100000,
    S_UPD   = 13'b0000001000000,
    S_RN    = 13'b0000010000000,
    S_DIVB  = 13'b0000100000000,
    S_DIR   = 13'b0001000000000,
    S_ORD   = 13'b0010000000000,
    S_OLD   = 13'b0100000000000,
    S_OWAIT = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [DATA_W-1:0] tol_r, tol_nxt;
  logic [NW-1:0] i_r, i_nxt, j_r, j_nxt, nm1_r, nm1_nxt;
  logic iss_done_r, iss_done_nxt;
  logic s1_v_r, s1_v_nxt, s1_first_r, s1_first_nxt, s1_last_r, s1_last_nxt;
  logic s2_v_r, s2_v_nxt, s2_first_r, s2_first_nxt, s2_last_r, s2_last_nxt;
  logic [NW-1:0] s1_i_r, s1_i_nxt, s2_i_r, s2_i_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [DATA_W-1:0] rr_r, rr_nxt, coef_r, coef_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic conv_r, conv_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic signed [DATA_W-1:0] out_sol_r, out_sol_nxt;

  logic signed [ACC_W-1:0] prod_a_r, prod_b_r;
  logic signed [DATA_W-1:0] s2_x_r, s2_rv_r;

  logic signed [DATA_W-1:0] m_rd, b_rd, x_rd, r_rd, p_rd, q_rd;
  logic m_we, b_we, x_we, r_we, p_we, q_we;
  logic [MAW-1:0] m_waddr, m_raddr;
  logic [NW-1:0] b_waddr, x_waddr, r_waddr, p_waddr, q_waddr, p_raddr;
  logic signed [DATA_W-1:0] x_wdata, r_wdata, p_wdata, q_wdata;

  logic signed [DATA_W-1:0] ma, mb, dot_res, x_upd, r_upd, p_dir;
  logic pass_active, issue, pass_done, accum, in_acc;
  logic [SIZE_W-1:0] s_eff;
  logic [EW-1:0] iter_ext;
  div_req_t div_req;
  div_rsp_t div_rsp;

  cgs_ram #(.W(DATA_W), .D(N * N)) u_mat (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(in_if.value), .raddr(m_raddr), .rdata(m_rd));
  cgs_ram #(.W(DATA_W), .D(N)) u_rhs (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(in_if.value), .raddr(i_r), .rdata(b_rd));
  cgs_ram #(.W(DATA_W), .D(N)) u_sol (
    .clk, .we(x_we), .waddr(x_waddr), .wdata(x_wdata), .raddr(i_r), .rdata(x_rd));
  cgs_ram #(.W(DATA_W), .D(N)) u_res (
    .clk, .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(i_r), .rdata(r_rd));
  cgs_ram #(.W(DATA_W), .D(N)) u_dir (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rd));
  cgs_ram #(.W(DATA_W), .D(N)) u_prd (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(i_r), .rdata(q_rd));

  cgs_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  // ram addressing and write-back
  always_comb begin
    in_acc  = in_if.valid && (state_r == S_IDLE);
    m_we    = in_acc && (action_t'(in_if.action) == ACT_LOAD_A)
              && (int'(in_if.row) < N) && (int'(in_if.column) < N);
    m_waddr = MAW'(in_if.row) * MAW'(N) + MAW'(in_if.column);
    b_we    = in_acc && (action_t'(in_if.action) == ACT_LOAD_B) && (int'(in_if.row) < N);
    b_waddr = NW'(in_if.row);
    m_raddr = MAW'(i_r) * MAW'(N) + MAW'(j_r);
    p_raddr = (state_r == S_AP) ? j_r : i_r;

    x_upd = sat32(ACC_W'(s2_x_r) + (prod_a_r >>> 16));
    r_upd = sat32(ACC_W'(s2_rv_r) - (prod_b_r >>> 16));
    p_dir = sat32(ACC_W'(s2_rv_r) + (prod_a_r >>> 16));

    x_we    = ((state_r == S_INIT) && s1_v_r) || ((state_r == S_UPD) && s2_v_r);
    x_waddr = (state_r == S_INIT) ? s1_i_r : s2_i_r;
    x_wdata = (state_r == S_INIT) ? '0 : x_upd;
    r_we    = x_we;
    r_waddr = x_waddr;
    r_wdata = (state_r == S_INIT) ? b_rd : r_upd;
    p_we    = ((state_r == S_INIT) && s1_v_r) || ((state_r == S_DIR) && s2_v_r);
    p_waddr = (state_r == S_INIT) ? s1_i_r : s2_i_r;
    p_wdata = (state_r == S_INIT) ? b_rd : p_dir;
  end

  // multiplier operands
  always_comb begin
    case (state_r)
      S_RR, S_RN: begin
        ma = r_rd;
        mb = r_rd;
      end
      S_AP: begin
        ma = m_rd;
        mb = p_rd;
      end
      S_PAP: begin
        ma = p_rd;
        mb = q_rd;
      end
      S_UPD, S_DIR: begin
        ma = coef_r;
        mb = p_rd;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    pass_active = state_r inside {S_INIT, S_RR, S_AP, S_PAP, S_UPD, S_RN, S_DIR};
    accum       = state_r inside {S_RR, S_AP, S_PAP, S_RN};
    issue       = pass_active && !iss_done_r;
    pass_done   = pass_active && iss_done_r && !s1_v_r && !s2_v_r;
    dot_res     = sat32(acc_r >>> 16);
    s_eff       = (size_r == '0) ? SIZE_W'(1) : size_r;
    if (s_eff > SIZE_W'(LIM)) begin
      s_eff = SIZE_W'(LIM);
    end
    iter_ext = EW'(iter_r);

    state_nxt     = state_r;
    size_nxt      = size_r;
    tol_nxt       = tol_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    nm1_nxt       = nm1_r;
    iss_done_nxt  = iss_done_r;
    acc_nxt       = acc_r;
    rr_nxt        = rr_r;
    coef_nxt      = coef_r;
    iter_nxt      = iter_r;
    conv_nxt      = conv_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_idx_nxt   = out_idx_r;
    out_sol_nxt   = out_sol_r;
    div_req.start = 1'b0;
    div_req.num   = rr_r;
    div_req.den   = dot_res;

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_SIZE: size_nxt = cfg_wdata[SIZE_W-1:0];
        CFG_TOL:  tol_nxt = cfg_wdata;
        default:  ;
      endcase
    end

    // issue stage
    s1_v_nxt     = issue;
    s1_i_nxt     = i_r;
    s1_first_nxt = (state_r == S_AP) ? (j_r == '0) : (i_r == '0);
    s1_last_nxt  = (state_r == S_AP) ? (j_r == nm1_r) : (i_r == nm1_r);
    if (issue) begin
      if (state_r == S_AP) begin
        if (j_r == nm1_r) begin
          j_nxt = '0;
          if (i_r == nm1_r) begin
            iss_done_nxt = 1'b1;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end else if (i_r == nm1_r) begin
        iss_done_nxt = 1'b1;
      end else begin
        i_nxt = i_r + 1'b1;
      end
    end

    s2_v_nxt     = s1_v_r;
    s2_i_nxt     = s1_i_r;
    s2_first_nxt = s1_first_r;
    s2_last_nxt  = s1_last_r;
    if (s2_v_r && accum) begin
      acc_nxt = sat_add64(s2_first_r ? '0 : acc_r, prod_a_r);
    end
    q_we    = (state_r == S_AP) && s2_v_r && s2_last_r;
    q_waddr = s2_i_r;
    q_wdata = sat32(acc_nxt >>> 16);

    case (state_r)
      S_IDLE: begin
        if (in_acc && (action_t'(in_if.action) == ACT_SOLVE)) begin
          nm1_nxt      = NW'(s_eff - 1'b1);
          iter_nxt     = '0;
          conv_nxt     = 1'b0;
          i_nxt        = '0;
          j_nxt        = '0;
          iss_done_nxt = 1'b0;
          state_nxt    = S_INIT;
        end
      end
      S_DIVA, S_DIVB: begin
        if (div_rsp.done) begin
          coef_nxt     = div_rsp.quo;
          i_nxt        = '0;
          iss_done_nxt = 1'b0;
          state_nxt    = (state_r == S_DIVA) ? S_UPD : S_DIR;
        end
      end
      S_ORD: state_nxt = S_OLD;
      S_OLD: begin
        out_sol_nxt   = x_rd;
        out_idx_nxt   = IDX_W'(i_r);
        out_last_nxt  = (i_r == nm1_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_if.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        if (pass_done) begin
          i_nxt        = '0;
          j_nxt        = '0;
          iss_done_nxt = 1'b0;
          case (state_r)
            S_INIT: begin
              iter_nxt  = IW'(1);
              state_nxt = S_RR;
            end
            S_RR: begin
              rr_nxt    = dot_res;
              state_nxt = S_AP;
            end
            S_AP: state_nxt = S_PAP;
            S_PAP: begin
              if (dot_res == '0) begin
                state_nxt = S_ORD;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIVA;
              end
            end
            S_UPD: state_nxt = S_RN;
            S_RN: begin
              div_req.num = dot_res;
              div_req.den = rr_r;
              if ($unsigned(dot_res) <= tol_r) begin
                conv_nxt  = 1'b1;
                state_nxt = S_ORD;
              end else if (rr_r == '0) begin
                state_nxt = S_ORD;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIVB;
              end
            end
            S_DIR: begin
              if (iter_r >= IW'(MAX_ITER)) begin
                state_nxt = S_ORD;
              end else begin
                iter_nxt  = iter_r + 1'b1;
                state_nxt = S_RR;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SIZE_W'(16);
      tol_r       <= DATA_W'(1);
      i_r         <= '0;
      j_r         <= '0;
      nm1_r       <= '0;
      iss_done_r  <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      iter_r      <= '0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      tol_r       <= tol_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      nm1_r       <= nm1_nxt;
      iss_done_r  <= iss_done_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      iter_r      <= iter_nxt;
      conv_r      <= conv_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    s1_i_r     <= s1_i_nxt;
    s1_first_r <= s1_first_nxt;
    s1_last_r  <= s1_last_nxt;
    s2_i_r     <= s2_i_nxt;
    s2_first_r <= s2_first_nxt;
    s2_last_r  <= s2_last_nxt;
    acc_r      <= acc_nxt;
    rr_r       <= rr_nxt;
    coef_r     <= coef_nxt;
    out_idx_r  <= out_idx_nxt;
    out_sol_r  <= out_sol_nxt;
    prod_a_r   <= ma * mb;
    prod_b_r   <= coef_r * q_rd;
    s2_x_r     <= x_rd;
    s2_rv_r    <= r_rd;
  end

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.index      = out_idx_r;
  assign out_if.solution   = out_sol_r;
  assign out_if.last       = out_last_r;
  assign out_if.converged  = conv_r;
  assign out_if.iterations = (iter_ext > EW'(127)) ? ITER_W'(127) : iter_ext[ITER_W-1:0];
endmodule
`default_nettype wire

FILE: hdl/cgs_checker.sv
// port-level checks of the solver core and their binding
`default_nettype none
`include "conjugate_gradient_solver_core_assert.svh"
module cgs_checker import cgs_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_last,
  input wire logic              out_converged,
  input wire logic [ITER_W-1:0] out_iterations
);
  `CGS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result item dropped")
  `CGS_ASSERT_IMPL(a_busy, clk, rst_n, out_valid, !in_ready, "input open while results pending")
  `CGS_ASSERT_NEXT(a_run_stable, clk, rst_n, out_valid && !out_last, $stable(out_converged) && $stable(out_iterations), "run status changed mid run")
  `CGS_ASSERT_IMPL(a_iter_nz, clk, rst_n, out_valid, out_iterations != '0, "result with no iteration")
endmodule

bind conjugate_gradient_solver_core cgs_checker u_cgs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_last       (out_if.last),
  .out_converged  (out_if.converged),
  .out_iterations (out_if.iterations)
);
`default_nettype wire

FILE: dv/tb_top.sv
// testbench for the conjugate gradient solver core: random load/solve phases vs a predictor
`timescale 1ns / 100ps
module tb_top;
  import cgs_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int NMAX = 16;
  localparam int ITER_CAP = 64;

  typedef struct {
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         column;
    logic signed [DATA_W-1:0] value;
  } load_item_t;

  typedef struct {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] solution;
    logic                     last;
    logic                     converged;
    logic [ITER_W-1:0]        iterations;
  } solution_item_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_wdata;

  cgs_in_if  in_ch ();
  cgs_out_if out_ch ();

  conjugate_gradient_solver_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  load_item_t     pend_q[$];
  solution_item_t solution_q[$];

  int mat_q[NMAX][NMAX];
  int rhs_q[NMAX];
  int x_q[NMAX];
  int r_q[NMAX];
  int p_q[NMAX];
  int ap_q[NMAX];
  logic [SIZE_W-1:0] size_reg;
  logic [31:0]       tol_reg;

  int errors;
  int items_sent;
  int solves_done;
  int results_seen;
  int converged_runs;

  // sender burst state and current item
  load_item_t cur_item;
  int burst_left;
  int gap_left;

  // receiver stall state
  int  mode_cnt;
  int  stall_mode;
  int  hold_cnt;
  bit  hold_req;
  bit  hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_SIZE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD_A;
    in_ch.row = '0;
    in_ch.column = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #40ms;
    $display("conjugate_gradient_solver_core test failed");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    end
    return s;
  endfunction

  function automatic int clip32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  function automatic int qdot(input int u[NMAX], input int v[NMAX], input int n);
    longint acc;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      acc = sat_sum(acc, longint'(u[i]) * longint'(v[i]));
    end
    return clip32(acc >>> 16);
  endfunction

  function automatic int qdiv(input int num, input int den);
    return clip32((longint'(num) * 64'sd65536) / longint'(den));
  endfunction

  task automatic cg_solve(input int n, output bit conv, output int iters);
    int rr, pap, alpha, rn, beta;
    bit done;
    for (int i = 0; i < NMAX; i++) begin
      x_q[i] = 0;
      r_q[i] = rhs_q[i];
      p_q[i] = rhs_q[i];
    end
    iters = 0;
    conv = 1'b0;
    done = 1'b0;
    while (!done) begin
      iters++;
      rr = qdot(r_q, r_q, n);
      for (int i = 0; i < n; i++) begin
        ap_q[i] = qdot(mat_q[i], p_q, n);
      end
      pap = qdot(p_q, ap_q, n);
      if (pap == 0) begin
        done = 1'b1;
      end else begin
        alpha = qdiv(rr, pap);
        for (int i = 0; i < n; i++) begin
          x_q[i] = clip32(longint'(x_q[i]) + ((longint'(alpha) * longint'(p_q[i])) >>> 16));
          r_q[i] = clip32(longint'(r_q[i]) - ((longint'(alpha) * longint'(ap_q[i])) >>> 16));
        end
        rn = qdot(r_q, r_q, n);
        if ($unsigned(rn) <= tol_reg) begin
          conv = 1'b1;
          done = 1'b1;
        end else if (rr == 0) begin
          done = 1'b1;
        end else begin
          beta = qdiv(rn, rr);
          for (int i = 0; i < n; i++) begin
            p_q[i] = clip32(longint'(r_q[i]) + ((longint'(beta) * longint'(p_q[i])) >>> 16));
          end
          if (iters >= ITER_CAP) begin
            done = 1'b1;
          end
        end
      end
    end
  endtask

  function automatic int active_size(input logic [SIZE_W-1:0] s);
    if (s == 0) begin
      return 1;
    end
    if (s > NMAX) begin
      return NMAX;
    end
    return int'(s);
  endfunction

  task automatic cg_apply_item(input load_item_t it);
    int n, iters;
    bit conv;
    solution_item_t res;
    case (it.action)
      ACT_LOAD_A: begin
        mat_q[it.row][it.column] = it.value;
      end
      ACT_LOAD_B: begin
        rhs_q[it.row] = it.value;
      end
      ACT_SOLVE: begin
        n = active_size(size_reg);
        cg_solve(n, conv, iters);
        solves_done++;
        if (conv) begin
          converged_runs++;
        end
        for (int i = 0; i < n; i++) begin
          res.index = IDX_W'(i);
          res.solution = x_q[i];
          res.last = (i == n - 1);
          res.converged = conv;
          res.iterations = (iters > 127) ? 7'd127 : iters[ITER_W-1:0];
          solution_q.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cg_apply_item(cur_item);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0 || pend_q.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (gap_left != 0) begin
            gap_left--;
          end
        end else begin
          cur_item = pend_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.action <= cur_item.action;
          in_ch.row <= cur_item.row;
          in_ch.column <= cur_item.column;
          in_ch.value <= cur_item.value;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      mode_cnt = 0;
      stall_mode = 0;
      hold_cnt = 0;
      hold_done = 1'b0;
    end else if (hold_cnt != 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt--;
    end else if (hold_req && !hold_done && out_ch.valid) begin
      out_ch.ready <= 1'b0;
      hold_cnt = 3000;
      hold_done = 1'b1;
    end else begin
      if (mode_cnt == 0) begin
        mode_cnt = $urandom_range(20, 80);
        stall_mode = $urandom_range(0, 3);
      end else begin
        mode_cnt--;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 4) == 0);
        default: out_ch.ready <= ~out_ch.ready;
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    solution_item_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (solution_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected item index %0d", out_ch.index));
      end else begin
        exp_res = solution_q.pop_front();
        if (out_ch.index !== exp_res.index)
          flag_mismatch($sformatf("index %0d, want %0d", out_ch.index, exp_res.index));
        if (out_ch.solution !== exp_res.solution)
          flag_mismatch($sformatf("solution[%0d] %h, want %h", exp_res.index,
                                  out_ch.solution, exp_res.solution));
        if (out_ch.last !== exp_res.last)
          flag_mismatch($sformatf("last[%0d] %b, want %b", exp_res.index,
                                  out_ch.last, exp_res.last));
        if (out_ch.converged !== exp_res.converged)
          flag_mismatch($sformatf("converged[%0d] %b, want %b", exp_res.index,
                                  out_ch.converged, exp_res.converged));
        if (out_ch.iterations !== exp_res.iterations)
          flag_mismatch($sformatf("iterations[%0d] %0d, want %0d", exp_res.index,
                                  out_ch.iterations, exp_res.iterations));
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pend_q.size() != 0 || in_ch.valid || solution_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(input logic [SIZE_W-1:0] sz, input logic [31:0] tol);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SIZE;
    cfg_wdata <= {{(DATA_W-SIZE_W){1'b0}}, sz};
    size_reg = sz;
    @(posedge clk);
    cfg_idx <= CFG_TOL;
    cfg_wdata <= tol;
    tol_reg = tol;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(input logic [ACT_W-1:0] act, input int r, input int c,
                           input logic [31:0] v);
    load_item_t it;
    it.action = act;
    it.row = IDX_W'(r);
    it.column = IDX_W'(c);
    it.value = v;
    pend_q.push_back(it);
    if (act != ACT_UNUSED) begin
      items_sent++;
    end
  endtask

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // kind: 0 well conditioned, 1 raw random, 2 zero right-hand side, 3 corner values
  task automatic run_phase(input logic [SIZE_W-1:0] sz, input logic [31:0] tol, input int kind);
    int n;
    logic [31:0] a_loc[NMAX][NMAX];
    logic [31:0] v;
    wait_idle();
    write_regs(sz, tol);
    n = active_size(sz);
    for (int i = 0; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        case (kind)
          0, 2: begin
            if (i == j) v = 32'h30000 + $urandom_range(0, 32'h50000);
            else v = $urandom_range(0, 32'h6000) - 32'h3000;
          end
          1: v = $urandom;
          default: v = corner_value();
        endcase
        a_loc[i][j] = v;
        a_loc[j][i] = (kind == 1 || kind == 3) ? $urandom : v;
      end
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        push_item(ACT_LOAD_A, i, j, a_loc[i][j]);
      end
      case (kind)
        0: v = $urandom_range(0, 32'h40000) - 32'h20000;
        1: v = $urandom;
        2: v = 0;
        default: v = corner_value();
      endcase
      push_item(ACT_LOAD_B, i, 0, v);
      if ($urandom_range(0, 7) == 0) begin
        push_item(ACT_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      end
    end
    push_item(ACT_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
    // trailing items offered while the solve holds the input
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) != 0)
        push_item(ACT_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      else
        push_item(ACT_LOAD_A, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
    end
  endtask

  initial begin
    int sel, kind;
    logic [SIZE_W-1:0] sz;
    logic [31:0] tol;
    errors = 0;
    items_sent = 0;
    solves_done = 0;
    results_seen = 0;
    converged_runs = 0;
    hold_req = 1'b0;
    size_reg = 5'd16;
    tol_reg = 32'd1;
    @(posedge rst_n);

    // directed: size zero acting as one, corner values, zero right-hand side
    run_phase(5'd0, 32'd1, 0);
    push_item(ACT_LOAD_A, 15, 15, 32'h80000000);
    push_item(ACT_LOAD_B, 15, 0, 32'h7FFFFFFF);
    push_item(ACT_UNUSED, 15, 15, 32'hFFFFFFFF);
    run_phase(5'd2, 32'd0, 3);
    run_phase(5'd1, 32'hFFFFFFFF, 0);
    run_phase(5'd3, 32'd1, 2);

    // full-size solve with an oversized size setting and a long output stall
    hold_req = 1'b1;
    run_phase(5'd31, 32'd1, 0);

    while (items_sent < 320) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        sz = 5'd0;
      end else begin
        sz = SIZE_W'($urandom_range(1, 6));
      end
      case ($urandom_range(0, 4))
        0: tol = 32'd0;
        1: tol = 32'd1;
        2: tol = $urandom_range(0, 32'h1000);
        3: tol = 32'hFFFFFFFF;
        default: tol = $urandom;
      endcase
      sel = $urandom_range(0, 9);
      kind = (sel < 7) ? 0 : sel - 6;
      run_phase(sz, tol, kind);
    end
    wait_idle();
    repeat (50) @(posedge clk);

    $display("ran %0d load items and %0d solves, %0d converged, %0d solution items checked",
             items_sent, solves_done, converged_runs, results_seen);
    if (errors == 0) begin
      $display("conjugate_gradient_solver_core test passed");
    end else begin
      $display("conjugate_gradient_solver_core test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/cgs_pkg.sv
hdl/cgs_in_if.sv
hdl/cgs_out_if.sv
hdl/cgs_ram.sv
hdl/cgs_div.sv
hdl/conjugate_gradient_solver_core.sv
hdl/cgs_checker.sv
dv/tb_top.sv
